FILE: rtl/gsm_pkg.sv
// ----------------------------------------------------------------------------
// Gesture sequence matcher package
// Field widths, action codes and default sizes shared by the matcher files.
// ----------------------------------------------------------------------------
package gsm_pkg;

  // Word field widths on the channels
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned GESTURE_W  = 4;
  localparam int unsigned TICKS_W    = 32;
  localparam int unsigned SEQ_IDX_W  = 3;
  localparam int unsigned STEP_IDX_W = 3;
  localparam int unsigned SEQ_LEN_W  = 4;
  localparam int unsigned GAP_W      = 32;
  localparam int unsigned MASK_W     = 8;

  // Default sizes of the combo store
  localparam int unsigned DEF_NUM_SEQUENCES = 8;
  localparam int unsigned DEF_MAX_STEPS     = 8;
  localparam int unsigned DEF_CODE_BITS     = 4;
  localparam int unsigned DEF_TIME_BITS     = 32;

  // Item actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_GESTURE = 2'd0,
    ACT_STEP    = 2'd1,
    ACT_DEFINE  = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

endpackage

FILE: rtl/gsm_if.sv
// ----------------------------------------------------------------------------
// Gesture sequence matcher channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface gsm_in_if;
  logic                                valid;
  logic                                ready;
  gsm_pkg::action_e                    action;
  logic [gsm_pkg::GESTURE_W-1:0]       gesture;
  logic [gsm_pkg::TICKS_W-1:0]         time_ticks;
  logic [gsm_pkg::SEQ_IDX_W-1:0]       seq_index;
  logic [gsm_pkg::STEP_IDX_W-1:0]      step_index;
  logic [gsm_pkg::SEQ_LEN_W-1:0]       seq_length;
  logic [gsm_pkg::GAP_W-1:0]           max_gap;

  modport source (
    output valid, action, gesture, time_ticks, seq_index, step_index, seq_length, max_gap,
    input  ready
  );
  modport sink (
    input  valid, action, gesture, time_ticks, seq_index, step_index, seq_length, max_gap,
    output ready
  );
endinterface

interface gsm_out_if;
  logic                          valid;
  logic                          ready;
  logic [gsm_pkg::MASK_W-1:0]    completed_mask;
  logic                          accepted;

  modport source (output valid, completed_mask, accepted, input ready);
  modport sink   (input valid, completed_mask, accepted, output ready);
endinterface

FILE: rtl/gesture_sequence_matcher_core.sv
// ----------------------------------------------------------------------------
// Gesture sequence matcher core
// Matches timestamped gesture codes against stored combos, one slot at a time
// through a shared gap comparator, and returns one result word per input word.
// ----------------------------------------------------------------------------
// Sequence: a nonzero gesture event visits every slot in turn, with slot read,
//   gap compare and step read, match and update per slot; step write and
//   define go straight to the result; clear progress writes every slot's progress.
// Throughput: one word at a time; the next word is taken once the core is idle,
//   even while the previous result still waits on the output register.
// Reset: a clearing pass over all NUM_SEQUENCES*MAX_STEPS entries zeroes the tables;
//   no input word is accepted during it.
module gesture_sequence_matcher_core #(
  parameter int unsigned NUM_SEQUENCES = gsm_pkg::DEF_NUM_SEQUENCES,
  parameter int unsigned MAX_STEPS     = gsm_pkg::DEF_MAX_STEPS,
  parameter int unsigned CODE_BITS     = gsm_pkg::DEF_CODE_BITS,
  parameter int unsigned TIME_BITS     = gsm_pkg::DEF_TIME_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gsm_in_if.sink            in_i,
  gsm_out_if.source         out_o
);

  localparam int unsigned SEQ_W     = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int unsigned STEP_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned LEN_W     = $clog2(MAX_STEPS + 1);
  localparam int unsigned TBL_DEPTH = NUM_SEQUENCES * MAX_STEPS;
  localparam int unsigned TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int unsigned CFG_W     = LEN_W + TIME_BITS;
  localparam int unsigned PROG_W    = STEP_W + TIME_BITS;
  localparam int unsigned MASK_W    = gsm_pkg::MASK_W;

  // State codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_TMO   = 3'd4;
  localparam logic [2:0] ST_MATCH = 3'd5;
  localparam logic [2:0] ST_CLRP  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [TBL_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [SEQ_W-1:0]  slot_q, slot_d;
  logic              out_valid_q, out_valid_d;

  // Latched word
  gsm_pkg::action_e                  act_q;
  logic [CODE_BITS-1:0]              code_q;
  logic [TIME_BITS-1:0]              now_q;
  logic [gsm_pkg::SEQ_IDX_W-1:0]     seq_q;
  logic [gsm_pkg::STEP_IDX_W-1:0]    stp_q;
  logic [gsm_pkg::SEQ_LEN_W-1:0]     len_in_q;
  logic [TIME_BITS-1:0]              gap_in_q;

  // Per-slot working registers
  logic [LEN_W-1:0]     len_q, len_d;
  logic [STEP_W-1:0]    p_q, p_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic [CODE_BITS-1:0] first_q, first_d;
  logic [MASK_W-1:0]    mask_q, mask_d;
  logic                 res_ok_q, res_ok_d;
  logic [MASK_W-1:0]    out_mask_q;
  logic                 out_ok_q;

  // RAM ports
  logic                 step_we, cfg_we, prog_we;
  logic [TBL_AW-1:0]    step_waddr, step_raddr;
  logic [CODE_BITS-1:0] step_wdata, step_rdata;
  logic [SEQ_W-1:0]     slot_waddr;
  logic [CFG_W-1:0]     cfg_wdata, cfg_rdata;
  logic [PROG_W-1:0]    prog_wdata, prog_rdata;

  // Slot word fields
  logic [LEN_W-1:0]     rd_len;
  logic [TIME_BITS-1:0] rd_gap;
  logic [STEP_W-1:0]    rd_p;
  logic [TIME_BITS-1:0] rd_last;
  logic [TIME_BITS-1:0] gap_diff;
  logic                 timed_out;
  logic                 stale;
  logic [STEP_W-1:0]    p_eff;
  logic [TBL_AW-1:0]    base_addr;

  // Match step
  logic                 hit;
  logic                 restart;
  logic [LEN_W-1:0]     p_inc;
  logic                 complete;
  logic [STEP_W-1:0]    p_new;

  // Item checks
  logic                 seq_ok;
  logic                 stp_ok;
  logic [LEN_W-1:0]     len_sat;

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_valid_q & out_o.ready;

  // Tables
  gsm_ram #(.WIDTH(CODE_BITS), .DEPTH(TBL_DEPTH)) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (step_we),
    .waddr_i (step_waddr),
    .wdata_i (step_wdata),
    .raddr_i (step_raddr),
    .rdata_o (step_rdata)
  );

  gsm_ram #(.WIDTH(CFG_W), .DEPTH(NUM_SEQUENCES)) u_cfg_ram (
    .clk_i   (clk_i),
    .we_i    (cfg_we),
    .waddr_i (slot_waddr),
    .wdata_i (cfg_wdata),
    .raddr_i (slot_q),
    .rdata_o (cfg_rdata)
  );

  gsm_ram #(.WIDTH(PROG_W), .DEPTH(NUM_SEQUENCES)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (slot_waddr),
    .wdata_i (prog_wdata),
    .raddr_i (slot_q),
    .rdata_o (prog_rdata)
  );

  // Slot word unpacking and the shared gap comparator
  assign rd_len    = cfg_rdata[TIME_BITS +: LEN_W];
  assign rd_gap    = cfg_rdata[TIME_BITS-1:0];
  assign rd_p      = prog_rdata[TIME_BITS +: STEP_W];
  assign rd_last   = prog_rdata[TIME_BITS-1:0];
  assign gap_diff  = now_q - rd_last;
  assign timed_out = (rd_p != '0) && (gap_diff > rd_gap);
  assign stale     = LEN_W'(rd_p) >= rd_len;
  assign p_eff     = (stale || timed_out) ? '0 : rd_p;
  assign base_addr = TBL_AW'(TBL_AW'(slot_q) * MAX_STEPS);

  // Match against the expected step
  assign hit      = (code_q == step_rdata);
  assign restart  = !hit && (code_q == first_q);
  assign p_inc    = LEN_W'(p_q) + LEN_W'(1);
  assign complete = hit && (p_inc == len_q);
  always_comb begin
    if (hit) begin
      p_new = complete ? '0 : STEP_W'(p_inc);
    end else if (restart) begin
      p_new = STEP_W'(1);
    end else begin
      p_new = '0;
    end
  end

  // Range checks on write and define words
  assign seq_ok  = 32'(seq_q) < NUM_SEQUENCES;
  assign stp_ok  = 32'(stp_q) < MAX_STEPS;
  assign len_sat = (32'(len_in_q) > MAX_STEPS) ? LEN_W'(MAX_STEPS) : LEN_W'(len_in_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    len_d       = len_q;
    p_d         = p_q;
    last_d      = last_q;
    first_d     = first_q;
    mask_d      = mask_q;
    res_ok_d    = res_ok_q;

    step_we     = 1'b0;
    step_waddr  = TBL_AW'(TBL_AW'(seq_q) * MAX_STEPS) + TBL_AW'(stp_q);
    step_wdata  = code_q;
    step_raddr  = base_addr;
    cfg_we      = 1'b0;
    prog_we     = 1'b0;
    slot_waddr  = SEQ_W'(seq_q);
    cfg_wdata   = {len_sat, gap_in_q};
    prog_wdata  = '0;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        step_we    = 1'b1;
        step_waddr = clr_cnt_q;
        step_wdata = '0;
        slot_waddr = SEQ_W'(clr_cnt_q);
        cfg_wdata  = '0;
        if (32'(clr_cnt_q) < NUM_SEQUENCES) begin
          cfg_we  = 1'b1;
          prog_we = 1'b1;
        end
        if (clr_cnt_q == TBL_AW'(TBL_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + TBL_AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_ok_d = 1'b1;
        mask_d   = '0;
        slot_d   = '0;
        state_d  = ST_DONE;
        unique case (act_q)
          gsm_pkg::ACT_GESTURE: begin
            if (code_q != '0) begin
              state_d = ST_RD;
            end
          end
          gsm_pkg::ACT_STEP: begin
            step_we  = seq_ok && stp_ok;
            res_ok_d = seq_ok && stp_ok;
          end
          gsm_pkg::ACT_DEFINE: begin
            cfg_we   = seq_ok && (len_in_q != '0);
            prog_we  = seq_ok && (len_in_q != '0);
            res_ok_d = seq_ok && (len_in_q != '0);
          end
          gsm_pkg::ACT_CLEAR: begin
            state_d = ST_CLRP;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_RD: begin
        // slot word and first step are read here
        state_d = ST_TMO;
      end
      ST_TMO: begin
        len_d      = rd_len;
        p_d        = p_eff;
        last_d     = rd_last;
        first_d    = step_rdata;
        step_raddr = base_addr + TBL_AW'(p_eff);
        state_d    = ST_MATCH;
      end
      ST_MATCH: begin
        slot_waddr = slot_q;
        prog_we    = (len_q != '0);
        prog_wdata = {p_new, (hit || restart) ? now_q : last_q};
        if (complete) begin
          mask_d = mask_q | (MASK_W'(1) << slot_q);
        end
        if (slot_q == SEQ_W'(NUM_SEQUENCES - 1)) begin
          state_d = ST_DONE;
        end else begin
          slot_d  = slot_q + SEQ_W'(1);
          state_d = ST_RD;
        end
      end
      ST_CLRP: begin
        slot_waddr = slot_q;
        prog_we    = 1'b1;
        if (slot_q == SEQ_W'(NUM_SEQUENCES - 1)) begin
          state_d = ST_DONE;
        end else begin
          slot_d = slot_q + SEQ_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q    <= in_i.action;
      code_q   <= CODE_BITS'(in_i.gesture);
      now_q    <= TIME_BITS'(in_i.time_ticks);
      seq_q    <= in_i.seq_index;
      stp_q    <= in_i.step_index;
      len_in_q <= in_i.seq_length;
      gap_in_q <= TIME_BITS'(in_i.max_gap);
    end
    len_q    <= len_d;
    p_q      <= p_d;
    last_q   <= last_d;
    first_q  <= first_d;
    mask_q   <= mask_d;
    res_ok_q <= res_ok_d;
    if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
      out_mask_q <= mask_q;
      out_ok_q   <= res_ok_q;
    end
  end

  // Channel outputs
  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.completed_mask = out_mask_q;
  assign out_o.accepted       = out_ok_q;

  // Checks
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD || state_q == ST_TMO || state_q == ST_MATCH || state_q == ST_CLRP)
      |-> (32'(slot_q) < NUM_SEQUENCES))
    else $error("slot counter beyond last combo slot");

  a_prog_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MATCH && len_q != '0) |-> (LEN_W'(p_new) < len_q))
    else $error("progress written at or above combo length");

  a_mask_only_gesture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && act_q != gsm_pkg::ACT_GESTURE) |-> (mask_q == '0))
    else $error("completion mask set by a non-gesture word");

  a_reject_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !res_ok_q)
      |-> (act_q == gsm_pkg::ACT_STEP || act_q == gsm_pkg::ACT_DEFINE))
    else $error("rejection on a word that cannot be rejected");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result word raised outside the done state");

endmodule

FILE: rtl/gsm_ram.sv
// ----------------------------------------------------------------------------
// Gesture sequence matcher RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gsm_ram #(
  parameter int unsigned WIDTH = gsm_pkg::GESTURE_W,
  parameter int unsigned DEPTH = gsm_pkg::DEF_NUM_SEQUENCES,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
